FILE: src/tphl_pkg.sv
// ----------------------------------------------------------------------------
// tphl_pkg
// Shared types and constants for the position history interpolator.
// ----------------------------------------------------------------------------
package tphl_pkg;

   localparam int HistDepth  = 16;
   localparam int SlotW      = $clog2(HistDepth);
   localparam int CountW     = $clog2(HistDepth + 1);
   localparam int TimeW      = 32;
   localparam int CoordW     = 32;
   localparam int AlphaW     = 17;
   localparam int EntryW     = TimeW + 3 * CoordW;

   localparam logic REQ_APPEND = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;

   typedef enum logic [1:0] {
      STAT_LERP   = 2'd0,
      STAT_OLDEST = 2'd1,
      STAT_NEWEST = 2'd2,
      STAT_EMPTY  = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [CoordW-1:0] z;
      logic signed [CoordW-1:0] y;
      logic signed [CoordW-1:0] x;
      logic [TimeW-1:0]         t;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_OLD,
      ST_RD_NEW,
      ST_CHK,
      ST_SCAN,
      ST_SCAN_CHK,
      ST_DIV,
      ST_MUL,
      ST_MUL_WAIT,
      ST_OUT
   } state_type;

   // divider request from the sequencer to the divider unit
   typedef struct packed {
      logic start;
      logic [TimeW-1:0] num;
      logic [TimeW-1:0] span;
   } div_ctl_type;

endpackage

FILE: src/timestamped_position_history_lerp_unit.sv
// ----------------------------------------------------------------------------
// timestamped_position_history_lerp_unit
// Ring of timestamped positions with clamped linear interpolation on query.
// ----------------------------------------------------------------------------
// Usage: items enter on req_* (stream handshake). An append item (tuser 0)
// stores a sample in the ring, overwriting the oldest when full, and gives no
// result. A query item (tuser 1) gives one result on rsp_*: the position at
// req time, clamped to the oldest or newest sample or interpolated between
// the bracketing pair, plus a status in rsp_tuser.
// Flow: an append is written to the ring as it is accepted. A query reads
// the ring through a single registered read port: newest and oldest sample
// first, a clamp if the query time lies outside them, else a scan of the
// stored pairs in order, a serial divide for alpha unless the span is
// zero, and a multiply (one coordinate per cycle). One item at a time is
// in flight. The result sits in an output register; the block waits in
// that state while rsp_tready is low and accepts the next item once it is
// taken. Reset empties the ring (fill count and write slot to zero); stored
// sample data is not cleared.
// ----------------------------------------------------------------------------
module timestamped_position_history_lerp_unit
   import tphl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: time_ticks[31:0], pos_x[63:32], pos_y[95:64], pos_z[127:96]
   input  logic [127:0] req_tdata,
   // tuser: req_type
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: out_x[31:0], out_y[63:32], out_z[95:64]
   output logic [95:0]  rsp_tdata,
   // tuser: lookup_status
   output logic [1:0]   rsp_tuser
);

   state_type state_ff, state_in;
   logic [SlotW-1:0]  wptr_ff, wptr_in;
   logic [CountW-1:0] fill_ff, fill_in;
   logic [CountW-1:0] idx_ff, idx_in;      // chronological index being read
   logic [TimeW-1:0]  qtime_ff, qtime_in;
   entry_type         ea_ff, ea_in, eb_ff, eb_in;
   logic [AlphaW-1:0] alpha_ff, alpha_in;
   logic [1:0]        mcnt_ff, mcnt_in;
   logic signed [CoordW-1:0] ox_ff, ox_in, oy_ff, oy_in, oz_ff, oz_in;
   logic [1:0]        stat_ff, stat_in;

   logic              wr_en;
   entry_type         wr_data;
   logic [SlotW-1:0]  rd_addr;
   entry_type         rd_data;
   div_ctl_type       dctl;
   logic              div_done;
   logic [AlphaW-1:0] div_alpha;

   logic signed [CoordW:0]          diff;
   logic signed [CoordW+AlphaW+1:0] prod;
   logic signed [CoordW+AlphaW+1:0] step;
   logic signed [CoordW-1:0]        ca, cb;
   logic [SlotW:0]                  slot_sum;

   tphl_mem u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wptr_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tphl_div u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (dctl),
      .done  (div_done),
      .alpha (div_alpha)
   );

   assign wr_data.t = req_tdata[31:0];
   assign wr_data.x = req_tdata[63:32];
   assign wr_data.y = req_tdata[95:64];
   assign wr_data.z = req_tdata[127:96];

   // chrono slot k = wptr - fill + k (mod depth)
   assign slot_sum = {1'b0, wptr_ff} + (SlotW+1)'(HistDepth)
                     - (SlotW+1)'(fill_ff) + (SlotW+1)'(idx_in);
   assign rd_addr  = SlotW'(slot_sum % HistDepth);

   // one coordinate per cycle through a shared multiplier
   always_comb begin
      unique case (mcnt_ff)
         2'd0:    begin ca = ea_ff.x; cb = eb_ff.x; end
         2'd1:    begin ca = ea_ff.y; cb = eb_ff.y; end
         default: begin ca = ea_ff.z; cb = eb_ff.z; end
      endcase
      diff = (CoordW+1)'(cb) - (CoordW+1)'(ca);
      prod = (CoordW+AlphaW+2)'(diff) * $signed({1'b0, alpha_ff});
      if (prod < 0) begin
         step = -((-prod) >>> 16);
      end else begin
         step = prod >>> 16;
      end
   end

   always_comb begin
      state_in = state_ff;
      wptr_in  = wptr_ff;
      fill_in  = fill_ff;
      idx_in   = idx_ff;
      qtime_in = qtime_ff;
      ea_in    = ea_ff;
      eb_in    = eb_ff;
      alpha_in = alpha_ff;
      mcnt_in  = mcnt_ff;
      ox_in    = ox_ff;
      oy_in    = oy_ff;
      oz_in    = oz_ff;
      stat_in  = stat_ff;
      wr_en    = 1'b0;
      dctl     = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            idx_in     = '0;
            if (req_tvalid) begin
               qtime_in = req_tdata[31:0];
               if (req_tuser == REQ_APPEND) begin
                  wr_en   = 1'b1;
                  wptr_in = SlotW'(({1'b0, wptr_ff} + 1'b1) % HistDepth);
                  if (fill_ff != CountW'(HistDepth)) begin
                     fill_in = fill_ff + 1'b1;
                  end
               end else if (fill_ff == '0) begin
                  ox_in = '0; oy_in = '0; oz_in = '0;
                  stat_in  = STAT_EMPTY;
                  state_in = ST_OUT;
               end else begin
                  idx_in   = fill_ff - 1'b1;   // read newest first
                  state_in = ST_RD_NEW;
               end
            end
         end
         ST_RD_NEW: begin
            eb_in    = rd_data;
            idx_in   = '0;
            state_in = ST_RD_OLD;
         end
         ST_RD_OLD: begin
            ea_in    = rd_data;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (qtime_ff <= ea_ff.t) begin
               ox_in = ea_ff.x; oy_in = ea_ff.y; oz_in = ea_ff.z;
               stat_in  = STAT_OLDEST;
               state_in = ST_OUT;
            end else if (qtime_ff >= eb_ff.t) begin
               ox_in = eb_ff.x; oy_in = eb_ff.y; oz_in = eb_ff.z;
               stat_in  = STAT_NEWEST;
               state_in = ST_OUT;
            end else begin
               // keep newest in ox.. for the no-bracket fallback
               ox_in = eb_ff.x; oy_in = eb_ff.y; oz_in = eb_ff.z;
               idx_in   = CountW'(1);
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            eb_in    = rd_data;
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (ea_ff.t <= qtime_ff && qtime_ff <= eb_ff.t) begin
               dctl.start = 1'b1;
               dctl.num   = qtime_ff - ea_ff.t;
               dctl.span  = eb_ff.t - ea_ff.t;
               if (eb_ff.t == ea_ff.t) begin
                  alpha_in = '0;
                  mcnt_in  = '0;
                  dctl.start = 1'b0;
                  state_in = ST_MUL;
               end else begin
                  state_in = ST_DIV;
               end
            end else if (idx_ff + 1'b1 >= fill_ff) begin
               stat_in  = STAT_NEWEST;
               state_in = ST_OUT;
            end else begin
               ea_in    = eb_ff;
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               alpha_in = div_alpha;
               mcnt_in  = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            unique case (mcnt_ff)
               2'd0:    ox_in = ca + CoordW'(step);
               2'd1:    oy_in = ca + CoordW'(step);
               default: oz_in = ca + CoordW'(step);
            endcase
            mcnt_in = mcnt_ff + 1'b1;
            if (mcnt_ff == 2'd2) begin
               stat_in  = STAT_LERP;
               state_in = ST_OUT;
            end
         end
         ST_MUL_WAIT: state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wptr_ff  <= '0;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         wptr_ff  <= wptr_in;
         fill_ff  <= fill_in;
      end
      idx_ff   <= idx_in;
      qtime_ff <= qtime_in;
      ea_ff    <= ea_in;
      eb_ff    <= eb_in;
      alpha_ff <= alpha_in;
      mcnt_ff  <= mcnt_in;
      ox_ff    <= ox_in;
      oy_ff    <= oy_in;
      oz_ff    <= oz_in;
      stat_ff  <= stat_in;
   end

   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {oz_ff, oy_ff, ox_ff};
   assign rsp_tuser  = stat_ff;

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CountW'(HistDepth)) else $error("fill count overflow");
   a_append_adv: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> wptr_ff == SlotW'(({1'b0, $past(wptr_ff)} + 1'b1) % HistDepth))
      else $error("write slot did not advance");
   a_empty_stat: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && fill_ff == '0) |-> rsp_tuser == STAT_EMPTY)
      else $error("empty ring gave non-empty status");
   a_alpha_max: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL |-> alpha_ff <= AlphaW'(65536))
      else $error("alpha above one");

endmodule

FILE: src/tphl_mem.sv
// ----------------------------------------------------------------------------
// tphl_mem
// Sample ring storage: one write port, one synchronous read port.
// ----------------------------------------------------------------------------
module tphl_mem
   import tphl_pkg::*;
(
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [SlotW-1:0]     wr_addr,
   input  entry_type            wr_data,
   input  logic [SlotW-1:0]     rd_addr,
   output entry_type            rd_data
);

   entry_type mem_ff [HistDepth];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/tphl_div.sv
// ----------------------------------------------------------------------------
// tphl_div
// Serial restoring divider: alpha = (num << 16) / span, one bit per cycle.
// ----------------------------------------------------------------------------
module tphl_div
   import tphl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  div_ctl_type       ctl,
   output logic              done,
   output logic [AlphaW-1:0] alpha
);

   localparam int QW = TimeW + 16;
   localparam int CntW = $clog2(QW + 1);

   logic [QW-1:0]   quo_ff, quo_in;
   logic [TimeW-1:0] rem_ff, rem_in;
   logic [TimeW-1:0] den_ff, den_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic [TimeW:0]  trial;
   logic [TimeW:0]  diff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, quo_ff[QW-1]};
      diff    = trial - {1'b0, den_ff};
      if (ctl.start) begin
         quo_in  = {ctl.num, 16'd0};
         rem_in  = '0;
         den_in  = ctl.span;
         cnt_in  = CntW'(QW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so it fits in TimeW bits
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[TimeW-1:0];
            quo_in = {quo_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = trial[TimeW-1:0];
            quo_in = {quo_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   // quotient never exceeds 1.0 since num <= span
   assign done  = busy_ff && (cnt_ff == CntW'(1));
   assign alpha = quo_in[AlphaW-1:0];

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !ctl.start) else $error("divider restarted while busy");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the position history interpolator: a directed table
// followed by random append/query traffic under varying idle and stall
// patterns, each result checked against a table value or a behavioral model of the ring.
// ----------------------------------------------------------------------------
module tb_top
   import tphl_pkg::*;
();

   localparam int  CycleLimit = 3000000;
   localparam int  RandItems  = 550;
   localparam int  DrainWait  = 200;

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      status_type  st;
   } position_result_type;

   typedef struct {
      logic        kind;
      logic [31:0] t;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      bit          typed;
      position_result_type res;
   } stim_row_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;
   logic         req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [95:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;

   timestamped_position_history_lerp_unit DUT (.*);

   // model of the ring
   logic [31:0] hist_t [HistDepth];
   logic [31:0] hist_x [HistDepth];
   logic [31:0] hist_y [HistDepth];
   logic [31:0] hist_z [HistDepth];
   int unsigned wr_slot;
   int unsigned fill;

   position_result_type pending_positions[$];
   int  error_count;
   int  cycle_count;
   int  idle_pct;
   int  stall_pct;
   int  hold_cycles;
   stim_row_type dir_rows[$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned ring_slot(input int unsigned k);
      return (wr_slot + 2 * HistDepth - fill + k) % HistDepth;
   endfunction

   function automatic logic [31:0] blend(input logic [31:0] a, input logic [31:0] b,
                                         input longint alpha);
      longint prod;
      prod = (longint'($signed(b)) - longint'($signed(a))) * alpha;
      return 32'(longint'($signed(a)) + prod / 65536);  // truncates toward zero
   endfunction

   function automatic position_result_type slot_result(input int unsigned s,
                                                       input status_type st);
      position_result_type r;
      r.x = hist_x[s];
      r.y = hist_y[s];
      r.z = hist_z[s];
      r.st = st;
      return r;
   endfunction

   function automatic position_result_type lookup_position(input logic [31:0] t);
      position_result_type r;
      int unsigned old_s, new_s, sa, sb;
      logic [31:0] span;
      longint alpha;
      if (fill == 0) begin
         r.x = '0; r.y = '0; r.z = '0; r.st = STAT_EMPTY;
         return r;
      end
      old_s = ring_slot(0);
      new_s = ring_slot(fill - 1);
      if (t <= hist_t[old_s]) return slot_result(old_s, STAT_OLDEST);
      if (t >= hist_t[new_s]) return slot_result(new_s, STAT_NEWEST);
      for (int unsigned i = 0; i + 1 < fill; i++) begin
         sa = ring_slot(i);
         sb = ring_slot(i + 1);
         if (hist_t[sa] <= t && t <= hist_t[sb]) begin
            span = hist_t[sb] - hist_t[sa];
            alpha = 0;
            if (span != 0)
               alpha = longint'({32'd0, t - hist_t[sa]} << 16) / longint'({32'd0, span});
            r.x = blend(hist_x[sa], hist_x[sb], alpha);
            r.y = blend(hist_y[sa], hist_y[sb], alpha);
            r.z = blend(hist_z[sa], hist_z[sb], alpha);
            r.st = STAT_LERP;
            return r;
         end
      end
      // no bracketing pair: only after out-of-order appends
      return slot_result(new_s, STAT_NEWEST);
   endfunction

   function automatic void store_sample(input logic [31:0] t, x, y, z);
      hist_t[wr_slot] = t;
      hist_x[wr_slot] = x;
      hist_y[wr_slot] = y;
      hist_z[wr_slot] = z;
      wr_slot = (wr_slot + 1) % HistDepth;
      if (fill < HistDepth) fill++;
   endfunction

   function automatic stim_row_type row(input logic kind, input logic [31:0] t, x, y, z,
                                        input bit typed = 0, input logic [31:0] ex = 0,
                                        input logic [31:0] ey = 0, input logic [31:0] ez = 0,
                                        input status_type est = STAT_LERP);
      stim_row_type r;
      r.kind = kind; r.t = t; r.x = x; r.y = y; r.z = z; r.typed = typed;
      r.res.x = ex; r.res.y = ey; r.res.z = ez; r.res.st = est;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got, exp);
      $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, exp);
      error_count++;
   endtask

   // Offer one item, wait for its acceptance and book its expected result.
   task automatic send_item(input stim_row_type r);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.kind;
      req_tdata  <= {r.z, r.y, r.x, r.t};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (r.kind == REQ_QUERY)
         pending_positions.push_back(r.typed ? r.res : lookup_position(r.t));
      else
         store_sample(r.t, r.x, r.y, r.z);
   endtask

   function automatic logic [31:0] any_coord();
      case ($urandom_range(5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         default: return $urandom;
      endcase
   endfunction

   function automatic stim_row_type random_item();
      logic [31:0] t, lo, hi;
      int unsigned pick;
      pick = $urandom_range(99);
      lo = (fill > 0) ? hist_t[ring_slot(0)] : 0;
      hi = (fill > 0) ? hist_t[ring_slot(fill - 1)] : 0;
      if (pick < 50) begin
         case ($urandom_range(9))
            0:       t = hi;
            1, 2, 3: t = hi + $urandom_range(3);
            4, 5, 6: t = hi + $urandom_range(1000);
            7, 8:    t = hi + $urandom_range(1 << 20);
            default: t = $urandom;  // out-of-order noise
         endcase
         return row(REQ_APPEND, t, any_coord(), any_coord(), any_coord());
      end
      if (pick < 85 && fill > 0 && hi > lo)
         t = lo + $urandom_range(hi - lo);
      else if (pick < 92)
         t = $urandom;
      else
         t = (pick[0]) ? lo : hi;
      return row(REQ_QUERY, t, $urandom, $urandom, $urandom);
   endfunction

   // result side: check, then pick readiness for the next cycle
   always @(posedge clock) begin
      position_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_positions.size() == 0) begin
            report_mismatch("unexpected item", rsp_tdata[31:0], '0);
         end else begin
            exp_r = pending_positions.pop_front();
            if (rsp_tdata[31:0] !== exp_r.x) report_mismatch("out_x", rsp_tdata[31:0], exp_r.x);
            if (rsp_tdata[63:32] !== exp_r.y)
               report_mismatch("out_y", rsp_tdata[63:32], exp_r.y);
            if (rsp_tdata[95:64] !== exp_r.z)
               report_mismatch("out_z", rsp_tdata[95:64], exp_r.z);
            if (rsp_tuser !== exp_r.st)
               report_mismatch("lookup_status", 32'(rsp_tuser), 32'(exp_r.st));
         end
      end
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      error_count = 0;
      cycle_count = 0;
      idle_pct = 0;
      stall_pct = 0;
      hold_cycles = 0;
      wr_slot = 0;
      fill = 0;

      dir_rows.push_back(row(REQ_QUERY, 0, 0, 0, 0, 1, 0, 0, 0, STAT_EMPTY));
      dir_rows.push_back(row(REQ_QUERY, '1, '1, '1, '1, 1, 0, 0, 0, STAT_EMPTY));
      dir_rows.push_back(row(REQ_APPEND, 100, 32'h7fffffff, 32'h80000000, 0));
      dir_rows.push_back(row(REQ_QUERY, 50, 0, 0, 0, 1,
                             32'h7fffffff, 32'h80000000, 0, STAT_OLDEST));
      dir_rows.push_back(row(REQ_QUERY, 100, 0, 0, 0, 1,
                             32'h7fffffff, 32'h80000000, 0, STAT_OLDEST));
      dir_rows.push_back(row(REQ_QUERY, 200, 0, 0, 0, 1,
                             32'h7fffffff, 32'h80000000, 0, STAT_NEWEST));
      dir_rows.push_back(row(REQ_APPEND, 300, 32'h80000000, 32'h7fffffff, '1));
      dir_rows.push_back(row(REQ_QUERY, 200, 0, 0, 0));
      dir_rows.push_back(row(REQ_QUERY, 101, 0, 0, 0));
      dir_rows.push_back(row(REQ_QUERY, 299, 0, 0, 0));
      dir_rows.push_back(row(REQ_APPEND, 300, 1, 2, 3));   // zero span pair
      dir_rows.push_back(row(REQ_APPEND, '1, 0, 0, 0));
      dir_rows.push_back(row(REQ_QUERY, 300, 0, 0, 0));
      dir_rows.push_back(row(REQ_QUERY, '1, 0, 0, 0, 1, 0, 0, 0, STAT_NEWEST));
      dir_rows.push_back(row(REQ_QUERY, 32'hfffffffe, 0, 0, 0));
      dir_rows.push_back(row(REQ_APPEND, 5, 32'h00010000, 32'hffff0000, 32'h12345678));
      dir_rows.push_back(row(REQ_QUERY, 200, 0, 0, 0));    // clamps: newest sample time is 5
      dir_rows.push_back(row(REQ_QUERY, 50, 0, 0, 0));
      dir_rows.push_back(row(REQ_QUERY, 0, 0, 0, 0));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send_item(dir_rows[i]);

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 81; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 81; end
            default: begin idle_pct = 24; stall_pct = 24; end
         endcase
         if (ph == 2) hold_cycles = 600;  // sender keeps offering meanwhile
         for (int n = 0; n < RandItems / 4; n++) begin
            send_item(random_item());
            if (n % 40 == 39) begin
               req_tvalid <= 1'b0;
               @(posedge clock);
               while (pending_positions.size() != 0) @(posedge clock);
            end
         end
      end
      req_tvalid <= 1'b0;
      while (pending_positions.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
      if (error_count == 0 && pending_positions.size() == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
